/* rtl/md5md_pkg.sv */
// md5md_pkg: shared types, constants and round tables for the MD5 digest unit.
// Depends on nothing; imported by md5md_round and md5_message_digest_unit.
`default_nettype none

package md5md_pkg;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  localparam logic [7:0] PadByte    = 8'h80;
  localparam logic [5:0] LenBytePos = 6'd56;
  localparam logic [3:0] LenLoWord  = 4'd14;
  localparam logic [3:0] LenHiWord  = 4'd15;
  localparam logic [5:0] LastRound  = 6'd63;
  localparam logic [1:0] TopLane    = 2'd3;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5md_abcd_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PAD   = 7'b0000010,
    S_ZERO  = 7'b0000100,
    S_C_PRE = 7'b0001000,
    S_C_RUN = 7'b0010000,
    S_C_ADD = 7'b0100000,
    S_OUT   = 7'b1000000
  } md5md_state_e;

  // message word used by a given round
  function automatic logic [3:0] word_index(input logic [5:0] step);
    logic [3:0] s4;
    logic [3:0] idx;
    s4 = step[3:0];
    case (step[5:4])
      2'd0:    idx = s4;
      2'd1:    idx = 4'(s4 * 4'd5 + 4'd1);
      2'd2:    idx = 4'(s4 * 4'd3 + 4'd5);
      default: idx = 4'(s4 * 4'd7);
    endcase
    return idx;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] step);
    logic [4:0] r;
    case ({step[5:4], step[1:0]})
      4'h0:    r = 5'd7;
      4'h1:    r = 5'd12;
      4'h2:    r = 5'd17;
      4'h3:    r = 5'd22;
      4'h4:    r = 5'd5;
      4'h5:    r = 5'd9;
      4'h6:    r = 5'd14;
      4'h7:    r = 5'd20;
      4'h8:    r = 5'd4;
      4'h9:    r = 5'd11;
      4'ha:    r = 5'd16;
      4'hb:    r = 5'd23;
      4'hc:    r = 5'd6;
      4'hd:    r = 5'd10;
      4'he:    r = 5'd15;
      default: r = 5'd21;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] step);
    logic [31:0] k;
    case (step)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] bswap32(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

`default_nettype wire

/* rtl/md5_message_digest_unit.sv */
// md5_message_digest_unit: streaming MD5 hash, one message byte per input word.
// Depends on md5md_pkg and md5md_round.
//
// Input channel (in_valid_i/in_ready_o) carries data_byte_i, byte_present_i
// and last_byte_i. A present byte is packed little-endian into a 16 x 32 bit
// block memory. The byte that fills a 64-byte block starts a compression (one
// read prefetch, 64 rounds at one round a cycle reading the block memory, one
// chaining add), during which in_ready_o is low.
// A word with last_byte_i set finishes the message: pad byte write, zero sweep
// up to word 15, then one or two compressions; two when the length no longer
// fits in the current block or the last byte fills it.
// Output channel (out_valid_o/out_ready_i) carries the digest in
// digest_head_o/digest_tail_o from an output register, so new bytes are
// accepted while a digest waits. A second digest waits in the unit until the
// first one is taken. After a digest the chaining words and bit count return
// to their initial values.
// Reset (rst_ni low) clears control state and bit count, presets chain_q;
// no clearing pass is needed since every block word is written before use.
`default_nettype none

module md5_message_digest_unit
  import md5md_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        byte_present_i,
  input  wire logic        last_byte_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [63:0] digest_head_o,
  output      logic [63:0] digest_tail_o
);

  md5md_state_e state_q, state_d;
  md5md_abcd_t  chain_q, chain_d;
  md5md_abcd_t  work_q, work_d;
  md5md_abcd_t  round_nxt;
  logic [63:0]  count_q, count_d;
  logic [31:0]  acc_q, acc_d;
  logic [5:0]   step_q, step_d;
  logic [3:0]   zidx_q, zidx_d;
  logic         pend_last_q, pend_last_d;
  logic         extra_q, extra_d;
  logic         fin_q, fin_d;
  logic         ovalid_q, ovalid_d;
  logic [63:0]  head_q, head_d;
  logic [63:0]  tail_q, tail_d;

  // block memory
  logic [31:0]  blk_mem [16];
  logic [31:0]  rd_q;
  logic [3:0]   rd_addr;
  logic         mem_we;
  logic [3:0]   mem_waddr;
  logic [31:0]  mem_wdata;

  logic [1:0]   lane;
  logic [3:0]   widx;
  logic [31:0]  low_mask;
  logic [7:0]   put_val;
  logic [31:0]  put_word;
  logic         out_free;

  assign lane     = count_q[4:3];
  assign widx     = count_q[8:5];
  assign out_free = ~ovalid_q | out_ready_i;

  always_comb begin
    case (lane)
      2'd0:    low_mask = 32'h0000_0000;
      2'd1:    low_mask = 32'h0000_00ff;
      2'd2:    low_mask = 32'h0000_ffff;
      default: low_mask = 32'h00ff_ffff;
    endcase
  end

  assign put_val  = (state_q == S_PAD) ? PadByte : data_byte_i;
  assign put_word = (acc_q & low_mask) | ({24'b0, put_val} << {lane, 3'b000});

  md5md_round u_round (
    .cur_i      (work_q),
    .msg_word_i (rd_q),
    .step_i     (step_q),
    .nxt_o      (round_nxt)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      blk_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= blk_mem[rd_addr];
  end

  always_comb begin
    state_d     = state_q;
    chain_d     = chain_q;
    work_d      = work_q;
    count_d     = count_q;
    acc_d       = acc_q;
    step_d      = step_q;
    zidx_d      = zidx_q;
    pend_last_d = pend_last_q;
    extra_d     = extra_q;
    fin_d       = fin_q;
    ovalid_d    = ovalid_q & ~out_ready_i;
    head_d      = head_q;
    tail_d      = tail_q;
    mem_we      = 1'b0;
    mem_waddr   = widx;
    mem_wdata   = put_word;
    rd_addr     = word_index(6'd0);
    in_ready_o  = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (byte_present_i) begin
            acc_d   = put_word;
            count_d = count_q + 64'd8;
            mem_we  = (lane == TopLane);
          end
          if (byte_present_i && count_q[8:3] == LastRound) begin
            pend_last_d = last_byte_i;
            state_d     = S_C_PRE;
          end else if (last_byte_i) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        mem_we  = 1'b1;
        fin_d   = 1'b1;
        extra_d = (count_q[8:3] >= LenBytePos);
        zidx_d  = widx + 4'd1;
        state_d = (widx == LenHiWord) ? S_C_PRE : S_ZERO;
      end
      S_ZERO: begin
        mem_we    = 1'b1;
        mem_waddr = zidx_q;
        if (!extra_q && zidx_q == LenLoWord) begin
          mem_wdata = count_q[31:0];
        end else if (!extra_q && zidx_q == LenHiWord) begin
          mem_wdata = count_q[63:32];
        end else begin
          mem_wdata = '0;
        end
        zidx_d = zidx_q + 4'd1;
        if (zidx_q == LenHiWord) begin
          state_d = S_C_PRE;
        end
      end
      S_C_PRE: begin
        work_d  = chain_q;
        step_d  = '0;
        state_d = S_C_RUN;
      end
      S_C_RUN: begin
        // rd_q holds this round's word; fetch the next one
        rd_addr = word_index(step_q + 6'd1);
        work_d  = round_nxt;
        step_d  = step_q + 6'd1;
        if (step_q == LastRound) begin
          state_d = S_C_ADD;
        end
      end
      S_C_ADD: begin
        chain_d.a = chain_q.a + work_q.a;
        chain_d.b = chain_q.b + work_q.b;
        chain_d.c = chain_q.c + work_q.c;
        chain_d.d = chain_q.d + work_q.d;
        if (pend_last_q) begin
          pend_last_d = 1'b0;
          state_d     = S_PAD;
        end else if (extra_q) begin
          // length did not fit: second block of zeros plus length
          extra_d = 1'b0;
          zidx_d  = '0;
          state_d = S_ZERO;
        end else if (fin_q) begin
          state_d = S_OUT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_free) begin
          ovalid_d  = 1'b1;
          head_d    = {bswap32(chain_q.a), bswap32(chain_q.b)};
          tail_d    = {bswap32(chain_q.c), bswap32(chain_q.d)};
          chain_d.a = InitA;
          chain_d.b = InitB;
          chain_d.c = InitC;
          chain_d.d = InitD;
          count_d   = '0;
          fin_d     = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chain_q.a   <= InitA;
      chain_q.b   <= InitB;
      chain_q.c   <= InitC;
      chain_q.d   <= InitD;
      count_q     <= '0;
      step_q      <= '0;
      zidx_q      <= '0;
      pend_last_q <= 1'b0;
      extra_q     <= 1'b0;
      fin_q       <= 1'b0;
      ovalid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      chain_q     <= chain_d;
      count_q     <= count_d;
      step_q      <= step_d;
      zidx_q      <= zidx_d;
      pend_last_q <= pend_last_d;
      extra_q     <= extra_d;
      fin_q       <= fin_d;
      ovalid_q    <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    acc_q  <= acc_d;
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign out_valid_o   = ovalid_q;
  assign digest_head_o = head_q;
  assign digest_tail_o = tail_q;

endmodule

`default_nettype wire

/* rtl/md5md_round.sv */
// md5md_round: one MD5 round step on the working words.
// Depends on md5md_pkg (round constants, rotation table, word struct).
`default_nettype none

module md5md_round
  import md5md_pkg::*;
(
  input  wire md5md_abcd_t  cur_i,
  input  wire logic [31:0]  msg_word_i,
  input  wire logic [5:0]   step_i,
  output      md5md_abcd_t  nxt_o
);

  logic [31:0] mix;
  logic [31:0] sum;
  logic [63:0] dbl;

  always_comb begin
    case (step_i[5:4])
      2'd0:    mix = (cur_i.b & cur_i.c) | (~cur_i.b & cur_i.d);
      2'd1:    mix = (cur_i.b & cur_i.d) | (cur_i.c & ~cur_i.d);
      2'd2:    mix = cur_i.b ^ cur_i.c ^ cur_i.d;
      default: mix = cur_i.c ^ (cur_i.b | ~cur_i.d);
    endcase
  end

  assign sum = cur_i.a + mix + msg_word_i + round_const(step_i);
  // upper half of the doubled word is the left rotation
  assign dbl = {sum, sum} << rot_amount(step_i);

  assign nxt_o.a = cur_i.d;
  assign nxt_o.d = cur_i.c;
  assign nxt_o.c = cur_i.b;
  assign nxt_o.b = cur_i.b + dbl[63:32];

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking testbench for md5_message_digest_unit.
// Holds its own MD5 predictor in a scoreboard class; needs only the RTL.

class digest_scoreboard;
  localparam bit [7:0] PAD_MARK    = 8'h80;
  localparam int unsigned LEN_SLOT = 56;
  localparam int unsigned LAST_POS = 63;

  bit [31:0] chain[4];
  bit [31:0] blk[16];
  bit [63:0] bit_len;
  bit [31:0] sine_k[64];
  int unsigned shift_tab[16];
  bit [127:0] digests_due[$];
  int unsigned errors;
  int unsigned words_noted;
  int unsigned fillers_noted;
  int unsigned digests_checked;

  function new();
    sine_k = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    shift_tab = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    errors = 0;
    words_noted = 0;
    fillers_noted = 0;
    digests_checked = 0;
    restart();
  endfunction

  function void restart();
    chain = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
    foreach (blk[i]) blk[i] = '0;
    bit_len = '0;
  endfunction

  function bit [31:0] rotl(bit [31:0] v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function bit [31:0] le_word(bit [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function void fold_block();
    bit [31:0] a, b, c, d, mix, sum, held;
    int unsigned ph, widx;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (int unsigned r = 0; r < 64; r++) begin
      ph = r / 16;
      case (ph)
        0: begin
          mix = (b & c) | (~b & d);
          widx = r;
        end
        1: begin
          mix = (b & d) | (c & ~d);
          widx = (5 * r + 1) % 16;
        end
        2: begin
          mix = b ^ c ^ d;
          widx = (3 * r + 5) % 16;
        end
        default: begin
          mix = c ^ (b | ~d);
          widx = (7 * r) % 16;
        end
      endcase
      sum = a + mix + blk[widx] + sine_k[r];
      held = d;
      d = c;
      c = b;
      b = b + rotl(sum, shift_tab[ph * 4 + r % 4]);
      a = held;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
  endfunction

  // lanes above the new byte are cleared, as in a fresh word
  function void place_byte(int unsigned pos, bit [7:0] v);
    int unsigned w, sh;
    bit [31:0] keep;
    w = pos / 4;
    sh = (pos % 4) * 8;
    keep = (32'h1 << sh) - 32'h1;
    blk[w] = (blk[w] & keep) | ({24'h0, v} << sh);
  endfunction

  function void note_word(bit [7:0] data, bit present, bit last);
    bit [63:0] total;
    int unsigned pos;
    if (present) begin
      pos = bit_len[8:3];
      place_byte(pos, data);
      bit_len += 64'd8;
      if (pos == LAST_POS) fold_block();
    end
    if (last) begin
      total = bit_len;
      pos = bit_len[8:3];
      place_byte(pos, PAD_MARK);
      for (int unsigned w = pos / 4 + 1; w < 16; w++) blk[w] = '0;
      // no room left for the length: one extra block
      if (pos >= LEN_SLOT) begin
        fold_block();
        foreach (blk[i]) blk[i] = '0;
      end
      blk[14] = total[31:0];
      blk[15] = total[63:32];
      fold_block();
      digests_due.push_back({le_word(chain[0]), le_word(chain[1]),
                             le_word(chain[2]), le_word(chain[3])});
      restart();
    end
    if (present || last) words_noted++;
    else fillers_noted++;
  endfunction

  function void check_digest(logic [63:0] head, logic [63:0] tail);
    bit [127:0] want;
    if (digests_due.size() == 0) begin
      $error("digest with no message pending: head %h tail %h", head, tail);
      errors++;
      return;
    end
    want = digests_due.pop_front();
    digests_checked++;
    if (head !== want[127:64]) begin
      $error("digest_head: expected %h, got %h", want[127:64], head);
      errors++;
    end
    if (tail !== want[63:0]) begin
      $error("digest_tail: expected %h, got %h", want[63:0], tail);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return digests_due.size();
  endfunction
endclass

module tb_top;
  typedef enum logic [1:0] {
    RX_OPEN, RX_PATTERN, RX_SPARSE, RX_LONG_HOLD
  } rx_mode_e;

  localparam int BoundaryLens[10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
  localparam int unsigned WordTarget = 900;
  localparam int unsigned DigestTarget = 15;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        byte_present_i = 1'b0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] digest_head_o;
  logic [63:0] digest_tail_o;

  digest_scoreboard sb;
  int          burst_left = 0;
  bit          draining = 1'b0;
  rx_mode_e    ready_mode = RX_OPEN;
  logic [15:0] ready_pat = 16'hffff;
  logic [7:0]  ready_tick = 8'h00;

  md5_message_digest_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .byte_present_i(byte_present_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digest_head_o (digest_head_o),
    .digest_tail_o (digest_tail_o)
  );

  always #5 clk_i = ~clk_i;

  // digest side: check on handshake, then pick next ready value
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_digest(digest_head_o, digest_tail_o);
    ready_tick <= ready_tick + 8'd1;
    if (ready_tick == 8'hff) begin
      ready_mode <= rx_mode_e'($urandom_range(0, 3));
      ready_pat <= 16'($urandom);
    end else begin
      ready_pat <= {ready_pat[14:0], ready_pat[15]};
    end
    if (draining) begin
      out_ready_i <= 1'b1;
    end else begin
      case (ready_mode)
        RX_OPEN:    out_ready_i <= 1'b1;
        RX_PATTERN: out_ready_i <= ready_pat[15];
        RX_SPARSE:  out_ready_i <= ($urandom_range(0, 3) == 0);
        default:    out_ready_i <= (ready_tick[6:0] > 7'd70);
      endcase
    end
  end

  // one word on the input channel; sender idles between bursts
  task automatic push_word(input logic [7:0] data, input logic present, input logic last);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 48);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= data;
    byte_present_i <= present;
    last_byte_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_word(data, present, last);
    burst_left--;
  endtask

  task automatic hold_until_digests_out();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    burst_left = $urandom_range(1, 48);
  endtask

  task automatic send_message(input int len);
    int unsigned fill;
    bit last_on_byte;
    logic [7:0] b;
    fill = $urandom_range(0, 9);
    last_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      // stray word with neither byte nor end
      if ($urandom_range(0, 19) == 0) push_word(8'($urandom), 1'b0, 1'b0);
      b = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hff : 8'($urandom);
      push_word(b, 1'b1, last_on_byte && (i == len - 1));
    end
    if (!last_on_byte) push_word(8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic int pick_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return $urandom_range(0, 24);
    if (roll < 85) return BoundaryLens[$urandom_range(0, 9)];
    return $urandom_range(25, 200);
  endfunction

  initial begin
    int msg_count;
    sb = new();
    msg_count = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty message first (byte field must be ignored), then short directed messages
    push_word(8'h5a, 1'b0, 1'b1);
    push_word(8'h00, 1'b1, 1'b1);
    push_word(8'hff, 1'b1, 1'b1);
    push_word(8'h3c, 1'b0, 1'b0);
    push_word(8'h61, 1'b1, 1'b0);
    push_word(8'h62, 1'b1, 1'b0);
    push_word(8'h63, 1'b1, 1'b1);
    push_word(8'h61, 1'b1, 1'b0);
    push_word(8'h62, 1'b1, 1'b0);
    push_word(8'h63, 1'b1, 1'b0);
    push_word(8'hc3, 1'b0, 1'b1);
    push_word(8'h80, 1'b1, 1'b0);
    push_word(8'h7f, 1'b0, 1'b0);
    push_word(8'h01, 1'b1, 1'b0);
    push_word(8'hfe, 1'b0, 1'b1);
    hold_until_digests_out();

    while (sb.words_noted < WordTarget || sb.digests_checked + sb.pending() < DigestTarget) begin
      send_message(pick_length());
      msg_count++;
      if (msg_count == 12) hold_until_digests_out();
    end

    in_valid_i <= 1'b0;
    draining <= 1'b1;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Run covered %0d message words and %0d stray words over %0d digests,",
             sb.words_noted, sb.fillers_noted, sb.digests_checked);
    $display("with sender bursts and receiver stalls, including block-boundary lengths.");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end
endmodule
